@@ src/smt_pkg.sv @@
// ---------------------------------------------------------------------------
// smt_pkg: shared types and constants of the shebang argument tokenizer
// Parse phases, status codes, byte constants and the item/result structs.
// ---------------------------------------------------------------------------
package smt_pkg;

    localparam int unsigned MAX_TOKENS_DEFAULT = 255;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_BANG   = 4'd1,
        PH_BLANK1 = 4'd2,
        PH_NAME   = 4'd3,
        PH_BLANK2 = 4'd4,
        PH_BSL    = 4'd5,
        PH_OUT    = 4'd6,
        PH_IN     = 4'd7,
        PH_SQ     = 4'd8,
        PH_DQ     = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_NOT = 2'd0,
        ST_OK  = 2'd1,
        ST_ERR = 2'd2
    } status_t;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
        logic       first_byte;
    } item_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_byte;
        logic       token_end;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] token_count;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

@@ src/shebang_meta_argument_tokenizer.sv @@
// ---------------------------------------------------------------------------
// shebang_meta_argument_tokenizer: shebang meta-argument tokenizer
// Checks a '#!' line for a trailing lone backslash and tokenizes the
// following meta line shell style, one script byte per transaction.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | in_byte, end_of_file, first_byte
//  out     | out_valid / out_ready| char_valid, out_byte, token_end,
//          |                      | done_res, status, token_count
//  cfg     | cfg_valid / cfg_ready| cfg_data (emit_chars)
//
// One byte per cycle sustained while no stalled result holds the parser; a
// byte passes the input register, the parser and the result register in turn.
// Bytes that give no result only pass through the parser state.
// A stalled result holds the parser only when the next byte has a result.
// Reset returns to the shebang check with emit_chars set; cfg is always ready.
// ---------------------------------------------------------------------------
module shebang_meta_argument_tokenizer #(
    parameter int unsigned MAX_TOKENS = smt_pkg::MAX_TOKENS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_file,
    input  logic       first_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       char_valid,
    output logic [7:0] out_byte,
    output logic       token_end,
    output logic       done_res,
    output logic [1:0] status,
    output logic [7:0] token_count,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import smt_pkg::*;

    logic    emit_reg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    fire;
    logic    has_res;
    result_t res;
    logic    out_valid_reg;
    result_t res_reg;
    logic    out_space;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            emit_reg <= cfg_data;
        end
    end

    assign in_item.in_byte     = in_byte;
    assign in_item.end_of_file = end_of_file;
    assign in_item.first_byte  = first_byte;

    smt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .consume    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    smt_core #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_chars (emit_reg),
        .item       (item),
        .fire       (fire),
        .has_res    (has_res),
        .res        (res)
    );

    assign out_space = !out_valid_reg || out_ready;
    assign fire      = item_valid && (!has_res || out_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_space)
        begin
            out_valid_reg <= fire && has_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_res)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_valid  = res_reg.char_valid;
    assign out_byte    = res_reg.out_byte;
    assign token_end   = res_reg.token_end;
    assign done_res    = res_reg.done_res;
    assign status      = res_reg.status;
    assign token_count = res_reg.token_count;

`ifndef SYNTH
    a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_valid || token_end || done_res))
        else $error("empty result transaction");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (status == ST_NOT && token_count == 8'h00))
        else $error("status or count set without done");

    a_char_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && char_valid) |-> !done_res)
        else $error("token character on final result");

    a_not_meta_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res && status == ST_NOT) |-> (token_count == 8'h00))
        else $error("count reported without meta line");
`endif

endmodule

@@ src/smt_in_stage.sv @@
// ---------------------------------------------------------------------------
// smt_in_stage: input register
// Holds one accepted byte transaction until the parser consumes it.
// ---------------------------------------------------------------------------
module smt_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  smt_pkg::item_t in_item,
    input  logic          consume,
    output logic          item_valid,
    output smt_pkg::item_t item
);
    import smt_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign in_ready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ src/smt_core.sv @@
// ---------------------------------------------------------------------------
// smt_core: parser state machine
// Shebang check, meta line tokenizer, token counter and result forming.
// ---------------------------------------------------------------------------
module smt_core #(
    parameter int unsigned MAX_TOKENS = smt_pkg::MAX_TOKENS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             emit_chars,
    input  smt_pkg::item_t   item,
    input  logic             fire,
    output logic             has_res,
    output smt_pkg::result_t res
);
    import smt_pkg::*;

    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int OW = (CW > 8) ? CW : 8;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TOKENS);

    phase_t        phase_reg, phase_next;
    logic          esc_reg, esc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          fin_reg, fin_next;

    // state as seen by this item, after an optional restart
    phase_t        p;
    logic          esc;
    logic [CW-1:0] cnt;
    logic          fin;

    logic [7:0] c;
    logic       eof;
    logic       nl;
    logic       cnt_inc;

    logic       chv, tend, done;
    status_t    st;
    logic [OW-1:0] cnt_ext;

    assign c   = item.in_byte;
    assign eof = item.end_of_file;
    assign nl  = (c == CH_NL);

    always_comb
    begin
        if (item.first_byte)
        begin
            p   = PH_START;
            esc = 1'b0;
            cnt = '0;
            fin = 1'b0;
        end
        else
        begin
            p   = phase_reg;
            esc = esc_reg;
            cnt = cnt_reg;
            fin = fin_reg;
        end
    end

    // next state
    always_comb
    begin
        phase_next = p;
        esc_next   = esc;
        cnt_inc    = 1'b0;
        if (!fin)
        begin
            unique case (p) inside
                PH_START:  if (!eof && c == CH_HASH) phase_next = PH_BANG;
                PH_BANG:   if (!eof && c == CH_BANG) phase_next = PH_BLANK1;
                PH_BLANK1: if (!eof && !nl && !is_blank(c)) phase_next = PH_NAME;
                PH_NAME:   if (!eof && is_blank(c)) phase_next = PH_BLANK2;
                PH_BLANK2: if (!eof && c == CH_BSL) phase_next = PH_BSL;
                PH_BSL:    if (!eof && nl) phase_next = PH_OUT;
                PH_OUT, PH_IN, PH_SQ, PH_DQ:
                begin
                    if (eof)
                    begin
                        phase_next = p;
                    end
                    else if (esc)
                    begin
                        esc_next = 1'b0;
                        if (!nl && p == PH_OUT)
                        begin
                            cnt_inc    = 1'b1;
                            phase_next = PH_IN;
                        end
                    end
                    else if (p == PH_SQ)
                    begin
                        if (c == CH_SQ) phase_next = PH_IN;
                    end
                    else if (p == PH_DQ)
                    begin
                        if (c == CH_DQ) phase_next = PH_IN;
                        else if (c == CH_BSL) esc_next = 1'b1;
                    end
                    else if (p == PH_IN)
                    begin
                        if (c == CH_DQ) phase_next = PH_DQ;
                        else if (c == CH_SQ) phase_next = PH_SQ;
                        else if (c == CH_BSL) esc_next = 1'b1;
                        else if (nl || is_blank(c)) phase_next = PH_OUT;
                    end
                    else
                    begin
                        // between tokens
                        if (c == CH_DQ)
                        begin
                            cnt_inc    = 1'b1;
                            phase_next = PH_DQ;
                        end
                        else if (c == CH_SQ)
                        begin
                            cnt_inc    = 1'b1;
                            phase_next = PH_SQ;
                        end
                        else if (c == CH_BSL)
                        begin
                            esc_next = 1'b1;
                        end
                        else if (!nl && !is_blank(c))
                        begin
                            cnt_inc    = 1'b1;
                            phase_next = PH_IN;
                        end
                    end
                end
                default: phase_next = p;
            endcase
        end
        cnt_next = (cnt_inc && cnt < CNT_MAX) ? cnt + 1'b1 : cnt;
        fin_next = fin || done;
    end

    // outputs
    always_comb
    begin
        chv  = 1'b0;
        tend = 1'b0;
        done = 1'b0;
        st   = ST_NOT;
        if (!fin)
        begin
            unique case (p) inside
                PH_START:
                    if (eof || c != CH_HASH) done = 1'b1;
                PH_BANG:
                    if (eof || c != CH_BANG)
                    begin
                        done = 1'b1;
                        st   = ST_ERR;
                    end
                PH_BLANK1:
                    if (eof || nl)
                    begin
                        done = 1'b1;
                        st   = ST_ERR;
                    end
                PH_NAME:
                    if (eof || nl) done = 1'b1;
                PH_BLANK2:
                    if (eof || nl || (c != CH_BSL && !is_blank(c))) done = 1'b1;
                PH_BSL:
                    if (eof || !nl) done = 1'b1;
                PH_OUT, PH_IN, PH_SQ, PH_DQ:
                begin
                    if (eof)
                    begin
                        done = 1'b1;
                        st   = (p == PH_OUT && !esc) ? ST_OK : ST_ERR;
                    end
                    else if (esc)
                    begin
                        chv = !nl;
                    end
                    else if (p == PH_SQ)
                    begin
                        chv = (c != CH_SQ);
                    end
                    else if (p == PH_DQ)
                    begin
                        chv = (c != CH_DQ) && (c != CH_BSL);
                    end
                    else if (p == PH_IN)
                    begin
                        if (nl)
                        begin
                            tend = 1'b1;
                            done = 1'b1;
                            st   = ST_OK;
                        end
                        else if (is_blank(c))
                        begin
                            tend = 1'b1;
                        end
                        else
                        begin
                            chv = (c != CH_DQ) && (c != CH_SQ) && (c != CH_BSL);
                        end
                    end
                    else
                    begin
                        if (nl)
                        begin
                            done = 1'b1;
                            st   = ST_OK;
                        end
                        else
                        begin
                            chv = !is_blank(c) && (c != CH_DQ) && (c != CH_SQ)
                                  && (c != CH_BSL);
                        end
                    end
                end
                default: done = 1'b0;
            endcase
        end
    end

    assign cnt_ext = OW'(cnt);

    always_comb
    begin
        res.char_valid  = chv && emit_chars;
        res.out_byte    = (chv && emit_chars) ? c : 8'h00;
        res.token_end   = tend && emit_chars;
        res.done_res    = done;
        res.status      = done ? st : ST_NOT;
        res.token_count = 8'h00;
        if (done && st != ST_NOT)
        begin
            res.token_count = (cnt_ext > OW'(255)) ? 8'hFF : cnt_ext[7:0];
        end
        has_res = res.char_valid || res.token_end || done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            esc_reg   <= 1'b0;
            cnt_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
